// ===== src/slt_pkg.sv =====
package slt_pkg;

	localparam int POS_BITS    = 16;
	localparam int KW_SLOTS    = 7;
	localparam int KW_CHARS    = 8;
	localparam int KW_BITS     = 8 * KW_CHARS;
	localparam int KW_IDX_BITS = 3;
	localparam int MAX_RES     = 3;
	localparam int RES_CNT_BITS = $clog2(MAX_RES + 1);

	typedef logic [POS_BITS-1:0] pos_t;
	localparam pos_t POS_MAX = '1;

	typedef enum logic [4:0] {
		K_LBRACE  = 5'd0,
		K_RBRACE  = 5'd1,
		K_LPAREN  = 5'd2,
		K_RPAREN  = 5'd3,
		K_COMMA   = 5'd4,
		K_SEMI    = 5'd5,
		K_ASSIGN  = 5'd6,
		K_EQEQ    = 5'd7,
		K_GT      = 5'd8,
		K_LT      = 5'd9,
		K_PLUS    = 5'd10,
		K_MINUS   = 5'd11,
		K_SLASH   = 5'd12,
		K_STAR    = 5'd13,
		K_NOT     = 5'd14,
		K_NEQ     = 5'd15,
		K_INT     = 5'd16,
		K_IDENT   = 5'd17,
		K_KEYWORD = 5'd18,
		K_END     = 5'd19,
		K_ILLEGAL = 5'd20,
		K_BADNUM  = 5'd21
	} kind_t;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	typedef struct packed {
		logic [7:0] code;
		logic       has_char;
		logic       line_end;
	} item_t;

	typedef struct packed {
		kind_t                  kind;
		pos_t                   start;
		pos_t                   length;
		logic [KW_IDX_BITS-1:0] kw;
	} tok_t;

	// all tokens caused by one character, in order
	typedef struct packed {
		logic [RES_CNT_BITS-1:0] count;
		tok_t [MAX_RES-1:0]      tok;
	} res_t;

	typedef struct packed {
		pos_t line_pos;
		logic idle;
	} lex_status_t;

endpackage

// ===== src/slt_lex.sv =====
module slt_lex import slt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              item,
	input  logic               fire,
	input  logic [KW_BITS-1:0] kw [KW_SLOTS],
	output res_t               res,
	output lex_status_t        status
);

	typedef enum logic [5:0] {
		M_IDLE = 6'b000001,
		M_INT  = 6'b000010,
		M_WORD = 6'b000100,
		M_EQ   = 6'b001000,
		M_BANG = 6'b010000,
		M_DROP = 6'b100000
	} mode_t;

	typedef struct packed {
		logic vld;
		tok_t tok;
	} opt_tok_t;

	localparam int BYTE_SEL = $clog2(KW_CHARS);

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	function automatic pos_t sat_inc(input pos_t v);
		return (v == POS_MAX) ? v : v + pos_t'(1);
	endfunction

	function automatic tok_t mk_tok(input kind_t k, input pos_t s, input pos_t l,
			input logic [KW_IDX_BITS-1:0] i);
		tok_t t;
		t.kind   = k;
		t.start  = s;
		t.length = l;
		t.kw     = i;
		return t;
	endfunction

	// {hit, slot}; lowest matching slot wins, zero slots never match
	function automatic logic [KW_IDX_BITS:0] kw_find(input logic [KW_BITS-1:0] w,
			input logic [KW_BITS-1:0] slots [KW_SLOTS]);
		logic [KW_IDX_BITS:0] found;
		found = '0;
		for (int s = KW_SLOTS - 1; s >= 0; s--) begin
			if (slots[s] != '0 && slots[s] == w) begin
				found = {1'b1, KW_IDX_BITS'(s)};
			end
		end
		return found;
	endfunction

	function automatic opt_tok_t single_tok(input logic [7:0] c, input pos_t p);
		opt_tok_t o;
		o     = '0;
		o.vld = 1'b1;
		case (c)
			CH_LBRACE: o.tok = mk_tok(K_LBRACE, p, pos_t'(1), '0);
			CH_RBRACE: o.tok = mk_tok(K_RBRACE, p, pos_t'(1), '0);
			CH_LPAREN: o.tok = mk_tok(K_LPAREN, p, pos_t'(1), '0);
			CH_RPAREN: o.tok = mk_tok(K_RPAREN, p, pos_t'(1), '0);
			CH_COMMA:  o.tok = mk_tok(K_COMMA,  p, pos_t'(1), '0);
			CH_SEMI:   o.tok = mk_tok(K_SEMI,   p, pos_t'(1), '0);
			CH_GT:     o.tok = mk_tok(K_GT,     p, pos_t'(1), '0);
			CH_LT:     o.tok = mk_tok(K_LT,     p, pos_t'(1), '0);
			CH_PLUS:   o.tok = mk_tok(K_PLUS,   p, pos_t'(1), '0);
			CH_MINUS:  o.tok = mk_tok(K_MINUS,  p, pos_t'(1), '0);
			CH_SLASH:  o.tok = mk_tok(K_SLASH,  p, pos_t'(1), '0);
			CH_STAR:   o.tok = mk_tok(K_STAR,   p, pos_t'(1), '0);
			default:   o.vld = 1'b0;
		endcase
		return o;
	endfunction

	// close out whatever token is pending in mode m
	function automatic opt_tok_t flush_tok(input mode_t m, input pos_t s, input pos_t l,
			input logic [KW_IDX_BITS:0] hit);
		opt_tok_t o;
		o     = '0;
		o.vld = 1'b1;
		unique case (m)
			M_INT:   o.tok = mk_tok(K_INT, s, l, '0);
			M_WORD: begin
				if (l <= pos_t'(KW_CHARS) && hit[KW_IDX_BITS]) begin
					o.tok = mk_tok(K_KEYWORD, s, l, hit[KW_IDX_BITS-1:0]);
				end else begin
					o.tok = mk_tok(K_IDENT, s, l, '0);
				end
			end
			M_EQ:    o.tok = mk_tok(K_ASSIGN, s, pos_t'(1), '0);
			M_BANG:  o.tok = mk_tok(K_NOT, s, pos_t'(1), '0);
			default: o.vld = 1'b0;
		endcase
		return o;
	endfunction

	mode_t              mode_q, mode_i, mode_n;
	pos_t               lp_q, lp_i, lp_n;
	pos_t               ps_q, ps_i, ps_n;
	pos_t               pl_q, pl_i, pl_n;
	logic [KW_BITS-1:0] wb_q, wb_i, wb_n;
	logic [KW_IDX_BITS:0] kw_cur, kw_new;
	logic [RES_CNT_BITS-1:0] nres;
	logic               do_flush, do_fresh;
	logic [7:0]         c;
	opt_tok_t           st, fl, fl_end;

	assign c      = item.code;
	assign kw_cur = kw_find(wb_q, kw);
	assign kw_new = kw_find(wb_i, kw);
	assign st     = single_tok(c, lp_q);
	assign fl     = flush_tok(mode_q, ps_q, pl_q, kw_cur);
	assign fl_end = flush_tok(mode_i, ps_i, pl_i, kw_new);

	always_comb begin
		res      = '0;
		nres     = '0;
		mode_i   = mode_q;
		lp_i     = lp_q;
		ps_i     = ps_q;
		pl_i     = pl_q;
		wb_i     = wb_q;
		do_flush = 1'b0;
		do_fresh = 1'b0;

		if (item.has_char) begin
			unique case (mode_q) inside
				M_DROP: begin
				end
				M_INT: begin
					if (is_digit(c)) begin
						pl_i = sat_inc(pl_q);
					end else if (is_letter(c)) begin
						res.tok[nres] = mk_tok(K_BADNUM, ps_q, sat_inc(pl_q), '0);
						nres          = nres + 1'b1;
						mode_i        = M_DROP;
					end else begin
						do_flush = 1'b1;
					end
				end
				M_WORD: begin
					if (is_letter(c)) begin
						if (pl_q < pos_t'(KW_CHARS)) begin
							wb_i[8*pl_q[BYTE_SEL-1:0] +: 8] = wb_q[8*pl_q[BYTE_SEL-1:0] +: 8] | c;
						end
						pl_i = sat_inc(pl_q);
					end else begin
						do_flush = 1'b1;
					end
				end
				M_EQ, M_BANG: begin
					if (c == CH_EQ) begin
						res.tok[nres] = mk_tok((mode_q == M_EQ) ? K_EQEQ : K_NEQ, ps_q,
							pos_t'(2), '0);
						nres          = nres + 1'b1;
						mode_i        = M_IDLE;
					end else begin
						do_flush = 1'b1;
					end
				end
				default: do_fresh = 1'b1;
			endcase

			if (do_flush) begin
				if (fl.vld) begin
					res.tok[nres] = fl.tok;
					nres          = nres + 1'b1;
				end
				do_fresh = 1'b1;
			end

			// start a new lexeme at the current position
			if (do_fresh) begin
				mode_i = M_IDLE;
				if (st.vld) begin
					res.tok[nres] = st.tok;
					nres          = nres + 1'b1;
				end else if (c == CH_EQ || c == CH_BANG) begin
					mode_i = (c == CH_EQ) ? M_EQ : M_BANG;
					ps_i   = lp_q;
					pl_i   = pos_t'(1);
				end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
				end else if (is_digit(c)) begin
					mode_i = M_INT;
					ps_i   = lp_q;
					pl_i   = pos_t'(1);
				end else if (is_letter(c)) begin
					mode_i = M_WORD;
					ps_i   = lp_q;
					pl_i   = pos_t'(1);
					wb_i   = KW_BITS'(c);
				end else begin
					res.tok[nres] = mk_tok(K_ILLEGAL, lp_q, pos_t'(1), '0);
					nres          = nres + 1'b1;
					mode_i        = M_DROP;
				end
			end

			lp_i = sat_inc(lp_q);
		end

		mode_n = mode_i;
		lp_n   = lp_i;
		ps_n   = ps_i;
		pl_n   = pl_i;
		wb_n   = wb_i;

		if (item.line_end) begin
			if (mode_i != M_DROP) begin
				if (fl_end.vld) begin
					res.tok[nres] = fl_end.tok;
					nres          = nres + 1'b1;
				end
				res.tok[nres] = mk_tok(K_END, lp_i, '0, '0);
				nres          = nres + 1'b1;
			end
			mode_n = M_IDLE;
			lp_n   = '0;
			ps_n   = '0;
			pl_n   = '0;
			wb_n   = '0;
		end

		res.count = nres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			lp_q   <= '0;
			ps_q   <= '0;
			pl_q   <= '0;
			wb_q   <= '0;
		end else if (fire) begin
			mode_q <= mode_n;
			lp_q   <= lp_n;
			ps_q   <= ps_n;
			pl_q   <= pl_n;
			wb_q   <= wb_n;
		end
	end

	assign status.line_pos = lp_q;
	assign status.idle     = (mode_q == M_IDLE);

endmodule

// ===== src/slt_outq.sv =====
module slt_outq import slt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic can_push,
	output tok_t out_tok,
	output logic out_last,
	output logic out_valid,
	input  logic out_ready
);

	res_t                    ent_q [2];
	logic                    rd_q, wr_q;
	logic [1:0]              cnt_q;
	logic [RES_CNT_BITS-1:0] sub_q;
	res_t                    head;
	logic                    pop_res, pop_ent;

	assign head      = ent_q[rd_q];
	assign out_valid = (cnt_q != 2'd0);
	assign out_tok   = head.tok[sub_q];
	assign out_last  = (sub_q == head.count - 1'b1);
	assign pop_res   = out_valid && out_ready;
	assign pop_ent   = pop_res && out_last;
	assign can_push  = (cnt_q != 2'd2) || pop_ent;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= '0;
			sub_q <= '0;
		end else begin
			wr_q  <= wr_q ^ push;
			rd_q  <= rd_q ^ pop_ent;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_ent};
			if (pop_ent) begin
				sub_q <= '0;
			end else if (pop_res) begin
				sub_q <= sub_q + 1'b1;
			end
		end
	end

endmodule

// ===== src/source_line_tokenizer.sv =====
// Path: a transferred character first waits in the input register; when the lexer fires,
//   its tokens are written into the output queue, and from there reach the token port.
// Throughput: one character per cycle while each character gives at most one token and
//   token_ready stays high; a character's tokens leave the token port one per transfer.
// Reset: arst_n clears the keyword slots, the scan state and all valid flags at once;
//   char_ready is already high when reset is released.
module source_line_tokenizer import slt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [KW_IDX_BITS-1:0] cfg_index,
	input  logic [KW_BITS-1:0]     cfg_data,
	input  logic                   char_valid,
	output logic                   char_ready,
	input  logic [7:0]             char_code,
	input  logic                   has_char,
	input  logic                   line_end,
	output logic                   token_valid,
	input  logic                   token_ready,
	output logic [4:0]             token_kind,
	output pos_t                   token_start,
	output pos_t                   token_length,
	output logic [KW_IDX_BITS-1:0] keyword_index,
	output logic                   last_of_item
);

	// Keyword slots: one 64-bit register each, written by index. An index past the
	// last slot matches no register and is dropped.
	logic [KW_BITS-1:0] kw_q [KW_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < KW_SLOTS; s++) begin
				kw_q[s] <= '0;
			end
		end else begin
			for (int s = 0; s < KW_SLOTS; s++) begin
				if (cfg_write && cfg_index == KW_IDX_BITS'(s)) begin
					kw_q[s] <= cfg_data;
				end
			end
		end
	end

	// Input register: one character waits here while the lexer decides on it.
	item_t       item_s1;
	logic        valid_s1;
	logic        fire;
	logic        push;
	logic        can_push;
	res_t        res;
	lex_status_t status;
	tok_t        q_tok;

	// Advance the lexer when the character in the input register can hand all of
	// its tokens to the output queue in one go. A character that makes no token
	// never waits for queue space.
	assign fire       = valid_s1 && ((res.count == '0) || can_push);
	assign push       = fire && (res.count != '0);
	assign char_ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (char_ready) begin
			item_s1 <= '{code: char_code, has_char: has_char, line_end: line_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	// Lexer: scan mode, line position and the pending lexeme; produces up to three
	// tokens per character (pending token, the character's own token, end of line).
	slt_lex u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (fire),
		.kw     (kw_q),
		.res    (res),
		.status (status)
	);

	// Output queue: two entries of one character's tokens each, drained one token
	// per transfer. The second entry lets the next character land while the last
	// token of the previous one still waits on token_ready.
	slt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (res),
		.can_push  (can_push),
		.out_tok   (q_tok),
		.out_last  (last_of_item),
		.out_valid (token_valid),
		.out_ready (token_ready)
	);

	assign token_kind    = q_tok.kind;
	assign token_start   = q_tok.start;
	assign token_length  = q_tok.length;
	assign keyword_index = q_tok.kw;

`ifndef SYNTHESIS
	// hold the buffered character while the queue has no room for its tokens
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

	// a line end always leaves the lexer at the start of a fresh line
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.line_end |=> status.line_pos == '0 && status.idle)
		else $error("lexer state not cleared after line end");

	// the end token closes its character's group of tokens
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == K_END |-> last_of_item)
		else $error("end token not last of its character");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import slt_pkg::*;

	// scan modes of the expected-token predictor
	typedef enum logic [2:0] {
		LX_IDLE,
		LX_INT,
		LX_WORD,
		LX_EQ,
		LX_BANG,
		LX_DROP
	} lex_mode_t;

	typedef struct {
		kind_t                  kind;
		pos_t                   start;
		pos_t                   length;
		logic [KW_IDX_BITS-1:0] kw;
		logic                   last;
	} token_rec_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [KW_IDX_BITS-1:0] cfg_index = '0;
	logic [KW_BITS-1:0]     cfg_data = '0;
	logic                   char_valid = 1'b0;
	logic                   char_ready;
	logic [7:0]             char_code = '0;
	logic                   has_char = 1'b0;
	logic                   line_end = 1'b0;
	logic                   token_valid;
	logic                   token_ready = 1'b0;
	logic [4:0]             token_kind;
	pos_t                   token_start;
	pos_t                   token_length;
	logic [KW_IDX_BITS-1:0] keyword_index;
	logic                   last_of_item;

	source_line_tokenizer dut (.*);

	// characters waiting to be driven, and tokens waiting to come out
	item_t      char_stream[$];
	token_rec_t expected_tokens[$];
	token_rec_t tok_burst[$];

	// predictor state and a shadow of the keyword registers
	lex_mode_t          lx_mode = LX_IDLE;
	pos_t               lx_pos = '0;
	pos_t               lx_start = '0;
	pos_t               lx_len = '0;
	logic [KW_BITS-1:0] lx_word = '0;
	logic [KW_BITS-1:0] kw_shadow [KW_SLOTS];
	logic [KW_BITS-1:0] kw_plan [KW_SLOTS];
	string              kw_words [KW_SLOTS];

	bit         idle_on = 1'b1;
	int         gap_left = 0;
	int         stall_left = 0;
	int         err_count = 0;
	int         checked_count = 0;
	int         char_count = 0;
	item_t      cur_item;
	token_rec_t want;

	initial begin
		forever #2 clk = ~clk;
	end

	// Bound the run well beyond the slowest legal schedule.
	initial begin
		#2_000_000;
		$display("run timed out with %0d tokens outstanding", expected_tokens.size());
		$display("FAILED: results differ");
		$finish;
	end

	//------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------
	function automatic pos_t sat_next(pos_t v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic bit is_dig(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_let(logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction

	// Queue one token of the current character; drop anything past the port's burst size.
	task automatic push_token(kind_t k, pos_t s, pos_t l, logic [KW_IDX_BITS-1:0] kw);
		token_rec_t r;
		r = '{k, s, l, kw, 1'b0};
		if (tok_burst.size() < MAX_RES)
			tok_burst.insert(tok_burst.size(), r);
	endtask

	// Close whatever lexeme is pending; a word becomes a keyword on an exact slot match.
	task automatic flush_pending();
		bit hit;
		hit = 1'b0;
		case (lx_mode)
			LX_INT: push_token(K_INT, lx_start, lx_len, '0);
			LX_WORD: begin
				if (lx_len <= KW_CHARS) begin
					for (int s = 0; s < KW_SLOTS; s++) begin
						if (!hit && kw_shadow[s] != '0 && kw_shadow[s] == lx_word) begin
							push_token(K_KEYWORD, lx_start, lx_len, KW_IDX_BITS'(s));
							hit = 1'b1;
						end
					end
				end
				if (!hit)
					push_token(K_IDENT, lx_start, lx_len, '0);
			end
			LX_EQ: push_token(K_ASSIGN, lx_start, 16'd1, '0);
			LX_BANG: push_token(K_NOT, lx_start, 16'd1, '0);
			default: ;
		endcase
		lx_mode = LX_IDLE;
	endtask

	// Classify a character seen with nothing pending.
	task automatic start_token(logic [7:0] c, pos_t here);
		case (c)
			CH_LBRACE: push_token(K_LBRACE, here, 16'd1, '0);
			CH_RBRACE: push_token(K_RBRACE, here, 16'd1, '0);
			CH_LPAREN: push_token(K_LPAREN, here, 16'd1, '0);
			CH_RPAREN: push_token(K_RPAREN, here, 16'd1, '0);
			CH_COMMA: push_token(K_COMMA, here, 16'd1, '0);
			CH_SEMI: push_token(K_SEMI, here, 16'd1, '0);
			CH_GT: push_token(K_GT, here, 16'd1, '0);
			CH_LT: push_token(K_LT, here, 16'd1, '0);
			CH_PLUS: push_token(K_PLUS, here, 16'd1, '0);
			CH_MINUS: push_token(K_MINUS, here, 16'd1, '0);
			CH_SLASH: push_token(K_SLASH, here, 16'd1, '0);
			CH_STAR: push_token(K_STAR, here, 16'd1, '0);
			CH_SPACE, CH_TAB, CH_NL: ;
			CH_EQ, CH_BANG: begin
				lx_mode = (c == CH_EQ) ? LX_EQ : LX_BANG;
				lx_start = here;
				lx_len = 16'd1;
			end
			default: begin
				if (is_dig(c)) begin
					lx_mode = LX_INT;
					lx_start = here;
					lx_len = 16'd1;
				end else if (is_let(c)) begin
					lx_mode = LX_WORD;
					lx_start = here;
					lx_len = 16'd1;
					lx_word = {{(KW_BITS-8){1'b0}}, c};
				end else begin
					push_token(K_ILLEGAL, here, 16'd1, '0);
					lx_mode = LX_DROP;
				end
			end
		endcase
	endtask

	// Advance the predictor by one accepted character transfer.
	task automatic tokenize_char(logic [7:0] c, logic hc, logic le);
		pos_t here;
		here = lx_pos;
		tok_burst.delete();
		if (hc) begin
			case (lx_mode)
				LX_DROP: ;
				LX_INT: begin
					if (is_dig(c)) begin
						lx_len = sat_next(lx_len);
					end else if (is_let(c)) begin
						push_token(K_BADNUM, lx_start, sat_next(lx_len), '0);
						lx_mode = LX_DROP;
					end else begin
						flush_pending();
						start_token(c, here);
					end
				end
				LX_WORD: begin
					if (is_let(c)) begin
						if (lx_len < KW_CHARS)
							lx_word[8*lx_len +: 8] = c;
						lx_len = sat_next(lx_len);
					end else begin
						flush_pending();
						start_token(c, here);
					end
				end
				LX_EQ, LX_BANG: begin
					if (c == CH_EQ) begin
						push_token((lx_mode == LX_EQ) ? K_EQEQ : K_NEQ, lx_start, 16'd2, '0);
						lx_mode = LX_IDLE;
					end else begin
						flush_pending();
						start_token(c, here);
					end
				end
				default: begin
					lx_mode = LX_IDLE;
					start_token(c, here);
				end
			endcase
			lx_pos = sat_next(lx_pos);
		end
		if (le) begin
			// an aborted line ends silently
			if (lx_mode != LX_DROP) begin
				flush_pending();
				push_token(K_END, lx_pos, 16'd0, '0);
			end
			lx_mode = LX_IDLE;
			lx_pos = '0;
			lx_start = '0;
			lx_len = '0;
			lx_word = '0;
		end
		if (tok_burst.size() > 0)
			tok_burst[tok_burst.size()-1].last = 1'b1;
		foreach (tok_burst[i])
			expected_tokens.insert(expected_tokens.size(), tok_burst[i]);
	endtask

	//------------------------------------------------------------------
	// Stimulus helpers
	//------------------------------------------------------------------
	// Mostly short gaps, now and then a long one; none when idling is off.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1) == 0)
			return CH_LA + 8'($urandom_range(0, 25));
		return CH_UA + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_single_op();
		case ($urandom_range(0, 11))
			0: return CH_LBRACE;
			1: return CH_RBRACE;
			2: return CH_LPAREN;
			3: return CH_RPAREN;
			4: return CH_COMMA;
			5: return CH_SEMI;
			6: return CH_GT;
			7: return CH_LT;
			8: return CH_PLUS;
			9: return CH_MINUS;
			10: return CH_SLASH;
			default: return CH_STAR;
		endcase
	endfunction

	function automatic bit is_known(logic [7:0] c);
		case (c)
			CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI, CH_EQ, CH_BANG,
			CH_GT, CH_LT, CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_SPACE, CH_TAB, CH_NL:
				return 1'b1;
			default: return is_dig(c) || is_let(c);
		endcase
	endfunction

	// Any code outside the character classes, NUL and the upper half included.
	function automatic logic [7:0] rand_illegal();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_known(c));
		return c;
	endfunction

	function automatic logic [KW_BITS-1:0] pack_word(string w);
		logic [KW_BITS-1:0] v;
		v = '0;
		for (int i = 0; i < w.len() && i < KW_CHARS; i++)
			v[8*i +: 8] = w[i];
		return v;
	endfunction

	task automatic push_raw(logic [7:0] c, logic hc, logic le);
		item_t it;
		it = '{code: c, has_char: hc, line_end: le};
		char_stream.insert(char_stream.size(), it);
	endtask

	task automatic push_text(string s, bit end_last);
		for (int i = 0; i < s.len(); i++)
			push_raw(s[i], 1'b1, end_last && i == s.len() - 1);
	endtask

	task automatic load_keywords(string w0, string w1, string w2, string w3,
			string w4, string w5, string w6);
		kw_words = '{w0, w1, w2, w3, w4, w5, w6};
		foreach (kw_words[s])
			kw_plan[s] = pack_word(kw_words[s]);
	endtask

	// Write every slot back to back; the block is idle whenever this runs.
	task automatic write_keywords();
		for (int s = 0; s < KW_SLOTS; s++) begin
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= KW_IDX_BITS'(s);
			cfg_data <= kw_plan[s];
			kw_shadow[s] = kw_plan[s];
		end
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// One random line: mostly well-formed tokens, sometimes glued together,
	// sometimes broken by an illegal code or a digit run running into a letter.
	task automatic gen_line(output int made);
		logic [7:0] line_bytes[$];
		int ntok, pick, n, k, at;
		bit end_inline;
		made = 0;
		ntok = $urandom_range(0, 8);
		for (int t = 0; t < ntok; t++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				k = $urandom_range(0, KW_SLOTS - 1);
				if (kw_words[k].len() > 0 && $urandom_range(0, 1) == 0) begin
					for (int i = 0; i < kw_words[k].len(); i++)
						line_bytes.insert(line_bytes.size(), kw_words[k][i]);
					// stretch a keyword so it no longer matches
					if ($urandom_range(0, 3) == 0) begin
						n = $urandom_range(1, 2);
						repeat (n) line_bytes.insert(line_bytes.size(), rand_letter());
					end
				end else begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 4);
					repeat (n) line_bytes.insert(line_bytes.size(), rand_letter());
				end
			end else if (pick < 50) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
				repeat (n) line_bytes.insert(line_bytes.size(), rand_digit());
			end else if (pick < 72) begin
				line_bytes.insert(line_bytes.size(), rand_single_op());
			end else if (pick < 86) begin
				line_bytes.insert(line_bytes.size(),
					($urandom_range(0, 1) == 0) ? CH_EQ : CH_BANG);
				if ($urandom_range(0, 1) == 0)
					line_bytes.insert(line_bytes.size(), CH_EQ);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: line_bytes.insert(line_bytes.size(), CH_SPACE);
						1: line_bytes.insert(line_bytes.size(), CH_TAB);
						default: line_bytes.insert(line_bytes.size(), CH_NL);
					endcase
				end
			end
			if ($urandom_range(0, 1) == 0)
				line_bytes.insert(line_bytes.size(), CH_SPACE);
		end

		pick = $urandom_range(0, 99);
		at = $urandom_range(0, line_bytes.size());
		if (pick < 8) begin
			line_bytes.insert(at, rand_illegal());
		end else if (pick < 14) begin
			line_bytes.insert(at, rand_letter());
			line_bytes.insert(at, rand_digit());
		end else if (pick < 17) begin
			line_bytes.insert(at, 8'($urandom_range(0, 255)));
		end

		// Close the line on its last character or with a separate empty item.
		end_inline = line_bytes.size() > 0 && $urandom_range(0, 1) == 0;
		foreach (line_bytes[i]) begin
			if ($urandom_range(0, 19) == 0)
				push_raw(8'($urandom), 1'b0, 1'b0);
			push_raw(line_bytes[i], 1'b1, end_inline && i == line_bytes.size() - 1);
			made++;
		end
		if (!end_inline) begin
			push_raw(8'($urandom), 1'b0, 1'b1);
			made++;
		end
	endtask

	task automatic gen_random(int target);
		int total, made;
		total = 0;
		while (total < target) begin
			gen_line(made);
			total += made;
		end
	endtask

	// Hold until every queued character is in and every token is out,
	// then go on waiting to prove nothing else arrives.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (char_stream.size() != 0 || char_valid || expected_tokens.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	//------------------------------------------------------------------
	// Character driver: present one item per transfer, with random gaps
	//------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			gap_left = 0;
		end else if (!char_valid || char_ready) begin
			// the slot is free: either idle it or load the next character
			if (gap_left > 0) begin
				gap_left--;
				char_valid <= 1'b0;
			end else if (char_stream.size() > 0) begin
				cur_item = char_stream.pop_front();
				char_valid <= 1'b1;
				char_code <= cur_item.code;
				has_char <= cur_item.has_char;
				line_end <= cur_item.line_end;
				gap_left = pick_gap();
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	//------------------------------------------------------------------
	// Monitor: predict on each character transfer, check each token transfer
	//------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ready <= 1'b0;
			stall_left = 0;
		end else begin
			// predict first so a same-edge token still finds its expectation
			if (char_valid && char_ready) begin
				tokenize_char(char_code, has_char, line_end);
				char_count++;
			end

			if (token_valid && token_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token: kind %0d start %0d length %0d",
						token_kind, token_start, token_length);
					err_count++;
				end else begin
					want = expected_tokens.pop_front();
					checked_count++;
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
						err_count++;
					end
					if (token_start !== want.start) begin
						$error("token_start: expected %0d, got %0d", want.start, token_start);
						err_count++;
					end
					if (token_length !== want.length) begin
						$error("token_length: expected %0d, got %0d", want.length, token_length);
						err_count++;
					end
					if (keyword_index !== want.kw) begin
						$error("keyword_index: expected %0d, got %0d", want.kw, keyword_index);
						err_count++;
					end
					if (last_of_item !== want.last) begin
						$error("last_of_item: expected %0d, got %0d", want.last, last_of_item);
						err_count++;
					end
				end
			end

			// stall the token port now and then
			if (stall_left > 0) begin
				stall_left--;
				token_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = pick_gap();
				token_ready <= 1'b0;
			end else begin
				token_ready <= 1'b1;
			end
		end
	end

	//------------------------------------------------------------------
	// Test sequence
	//------------------------------------------------------------------
	initial begin
		foreach (kw_shadow[s])
			kw_shadow[s] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Keyword set with a duplicate slot (lowest index must win), a full
		// eight-letter keyword, an all-ones slot and a disabled slot.
		idle_on = 1'b1;
		load_keywords("fn", "let", "if", "continue", "fn", "", "");
		kw_plan[5] = '1;
		write_keywords();

		// Directed: every single-character kind, = and ! resolved by the next
		// character, keyword and int, whitespace, a separate end item, an
		// ignored empty item, a digit run hitting a letter and an illegal code.
		push_text("{}(),;=><+-/*!", 1'b1);
		push_text("fn==7", 1'b0);
		push_raw(8'hFF, 1'b0, 1'b0);
		push_text("\t!=", 1'b0);
		push_raw(8'h00, 1'b0, 1'b1);
		push_text("9z+", 1'b1);
		push_raw(8'h80, 1'b1, 1'b0);
		push_text("a", 1'b0);
		push_raw(8'h55, 1'b0, 1'b1);
		push_raw(8'h00, 1'b1, 1'b1);
		push_text("continues", 1'b1);
		wait_quiet();

		gen_random(130);
		wait_quiet();

		// Second setting, streamed with no idling on either side.
		load_keywords("a", "Z", "zzzzzzzz", "AbCdEfGh", "ab", "", "a");
		kw_plan[5] = '1;
		write_keywords();
		idle_on = 1'b0;
		gen_random(130);
		wait_quiet();

		// Back to the reset value: every slot disabled.
		load_keywords("", "", "", "", "", "", "");
		write_keywords();
		idle_on = 1'b1;
		gen_random(130);
		wait_quiet();

		$display("Ran %0d character transfers and checked %0d tokens under three keyword sets,",
			char_count, checked_count);
		$display("including aborted lines, empty items and long words.");
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
